@@ src/linear_probe_hash_table_unit_defines.svh @@
// Assertion macros shared by the hash table RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LPHT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpht assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpht assertion failed");

`endif

@@ src/lpht_pkg.sv @@
// Package for the linear probing hash table: sizes, status codes, beat types.
// No dependencies; used by linear_probe_hash_table_unit.
package lpht_pkg;

   localparam int LOG2_SLOTS = 12;
   localparam int ADDR_W     = LOG2_SLOTS;
   localparam int SLOTS      = 1 << LOG2_SLOTS;
   localparam int KEY_W      = 64;
   localparam int IDX_W      = 12;
   localparam int CNT_W      = LOG2_SLOTS + 1;
   localparam int LOAD_W     = LOG2_SLOTS + 3;
   localparam int CFG_W      = 4;

   localparam logic [CFG_W-1:0] LOG2_MIN   = CFG_W'(4);
   localparam logic [CFG_W-1:0] LOG2_MAX   = CFG_W'((LOG2_SLOTS > 15) ? 15 :
                                                    ((LOG2_SLOTS < 4) ? 4 : LOG2_SLOTS));
   localparam logic [CFG_W-1:0] LOG2_RESET = CFG_W'((LOG2_SLOTS < 12) ? LOG2_SLOTS : 12);

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_INSERTED  = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic             op;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] slot_index;
      logic [1:0]       status;
   } rsp_type;

   // Saturate a written size to the supported range.
   function automatic logic [CFG_W-1:0] clamp_log2(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      r = v;
      if (r < LOG2_MIN) begin
         r = LOG2_MIN;
      end
      if (r > LOG2_MAX) begin
         r = LOG2_MAX;
      end
      return r;
   endfunction

endpackage

@@ src/linear_probe_hash_table_unit.sv @@
// Linear probing hash table of 64-bit keys with a one-read, one-write slot memory.
// Depends on lpht_pkg and linear_probe_hash_table_unit_defines.svh.
//
// A request is taken when start is high and busy is low; it carries a lookup
// or a get-or-insert of one key (key 0 is stored as 1). The block reads one
// slot of its key memory per cycle, starting at the home slot (key masked to
// the table size) and walking forward with wraparound, probing from 1 up to
// the table size slots and taking no new request until done; an insert of a
// new key returns full once the table is at its 75% load cap. The result
// appears on rsp_item for exactly one cycle with rsp_valid high and cannot be
// stalled. After reset, and after every csr write of table_size_log2, a
// clearing pass zeroes the slot memory one entry per cycle, 4096 entries
// after reset and 2^table_size_log2 (the written size clamped to 4..12)
// after a write, while busy stays high.
`include "linear_probe_hash_table_unit_defines.svh"

module linear_probe_hash_table_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lpht_pkg::req_type             req_item,
   output logic                          rsp_valid,
   output lpht_pkg::rsp_type             rsp_item,
   input  logic                          csr_we,
   input  logic [lpht_pkg::CFG_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_CLEAR = 3'b010,
      S_PROBE = 3'b100
   } state_type;

   // Slot key memory, one read and one write port, registered read data
   logic [lpht_pkg::KEY_W-1:0] slot_keys_ff [lpht_pkg::SLOTS];

   state_type                    state_ff, state_in;
   logic [lpht_pkg::CFG_W-1:0]   log2_ff, log2_in;
   logic [lpht_pkg::CNT_W-1:0]   used_ff, used_in;
   logic [lpht_pkg::ADDR_W-1:0]  clr_ff, clr_in;
   logic                         op_ff, op_in;
   logic [lpht_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [lpht_pkg::ADDR_W-1:0]  idx_ff, idx_in;
   logic [lpht_pkg::ADDR_W-1:0]  step_ff, step_in;
   logic [lpht_pkg::KEY_W-1:0]   rd_key_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   lpht_pkg::rsp_type            rsp_item_ff, rsp_item_in;

   logic                         mem_we;
   logic [lpht_pkg::ADDR_W-1:0]  mem_waddr;
   logic [lpht_pkg::KEY_W-1:0]   mem_wdata;
   logic [lpht_pkg::ADDR_W-1:0]  mem_raddr;

   logic [lpht_pkg::ADDR_W-1:0]  mask;
   logic [lpht_pkg::KEY_W-1:0]   req_key;
   logic [lpht_pkg::LOAD_W-1:0]  used_x4;
   logic [lpht_pkg::LOAD_W-1:0]  cap_x3;
   logic                         load_ok;
   logic                         hit_empty;
   logic                         hit_key;
   logic                         last_probe;
   logic                         accept;

   // Derived size terms
   assign mask    = ~({lpht_pkg::ADDR_W{1'b1}} << log2_ff);
   assign used_x4 = lpht_pkg::LOAD_W'(used_ff) << 2;
   assign cap_x3  = lpht_pkg::LOAD_W'(3) << log2_ff;
   assign load_ok = used_x4 < cap_x3;

   // Remap key zero, which marks an empty slot
   assign req_key = (req_item.key == '0) ? lpht_pkg::KEY_W'(1) : req_item.key;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Probe outcome of the slot read last cycle
   assign hit_empty  = (rd_key_ff == '0);
   assign hit_key    = (rd_key_ff == key_ff);
   assign last_probe = (step_ff == mask);

   // Sequencer: clear sweep, accept, probe walk, write-back
   always_comb begin
      state_in     = state_ff;
      log2_in      = log2_ff;
      used_in      = used_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = '0;
      mem_raddr    = idx_ff;

      if (csr_we) begin
         // New size: restart the sweep and drop all entries
         log2_in  = lpht_pkg::clamp_log2(csr_wdata);
         used_in  = '0;
         clr_in   = '0;
         state_in = S_CLEAR;
      end else begin
         case (state_ff)
            S_IDLE: begin
               mem_raddr = req_key[lpht_pkg::ADDR_W-1:0] & mask;
               if (accept) begin
                  op_in    = req_item.op;
                  key_in   = req_key;
                  idx_in   = req_key[lpht_pkg::ADDR_W-1:0] & mask;
                  step_in  = '0;
                  state_in = S_PROBE;
               end
            end
            S_CLEAR: begin
               mem_we    = 1'b1;
               mem_waddr = clr_ff;
               mem_wdata = '0;
               clr_in    = clr_ff + 1'b1;
               if (clr_ff == mask) begin
                  state_in = S_IDLE;
               end
            end
            S_PROBE: begin
               rsp_item_in.slot_index = '0;
               if (hit_empty) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  if (op_ff == lpht_pkg::OP_INSERT && load_ok) begin
                     // Claim the empty slot
                     mem_we                 = 1'b1;
                     mem_waddr              = idx_ff;
                     mem_wdata              = key_ff;
                     used_in                = used_ff + 1'b1;
                     rsp_item_in.slot_index = lpht_pkg::IDX_W'(idx_ff);
                     rsp_item_in.status     = lpht_pkg::ST_INSERTED;
                  end else if (op_ff == lpht_pkg::OP_INSERT) begin
                     rsp_item_in.status = lpht_pkg::ST_FULL;
                  end else begin
                     rsp_item_in.status = lpht_pkg::ST_NOT_FOUND;
                  end
               end else if (hit_key) begin
                  rsp_valid_in           = 1'b1;
                  state_in               = S_IDLE;
                  rsp_item_in.slot_index = lpht_pkg::IDX_W'(idx_ff);
                  rsp_item_in.status     = lpht_pkg::ST_FOUND;
               end else if (last_probe) begin
                  // Every slot in use was seen
                  rsp_valid_in       = 1'b1;
                  state_in           = S_IDLE;
                  rsp_item_in.status = (op_ff == lpht_pkg::OP_INSERT) ?
                                       lpht_pkg::ST_FULL : lpht_pkg::ST_NOT_FOUND;
               end else begin
                  // Advance to the next slot and issue its read
                  idx_in    = (idx_ff + 1'b1) & mask;
                  step_in   = step_ff + 1'b1;
                  mem_raddr = (idx_ff + 1'b1) & mask;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   // Slot memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_keys_ff[mem_waddr] <= mem_wdata;
      end
      rd_key_ff <= slot_keys_ff[mem_raddr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         log2_ff      <= lpht_pkg::LOG2_RESET;
         used_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         log2_ff      <= log2_in;
         used_ff      <= used_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      step_ff     <= step_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Checks
   `LPHT_ASSERT_NOW(a_load_cap, clock, reset, 1'b1, used_x4 <= cap_x3)
   `LPHT_ASSERT_NOW(a_rsp_after_probe, clock, reset, rsp_valid_ff,
                    $past(state_ff) == S_PROBE && state_ff == S_IDLE)
   `LPHT_ASSERT_NEXT(a_insert_counts, clock, reset,
                     rsp_valid_in && rsp_item_in.status == lpht_pkg::ST_INSERTED && !csr_we,
                     used_ff == $past(used_ff) + 1'b1)
   `LPHT_ASSERT_NOW(a_slot_in_table, clock, reset,
                    state_ff == S_PROBE,
                    (idx_ff & ~mask) == '0 && (step_ff & ~mask) == '0)

endmodule
